/* rtl/skc_pkg.sv */
// ----------------------------------------------------------------------------
// skc_pkg
// Types, constants and table functions of the soft-knee compressor gain block.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LVL_W          = 24;
    localparam int GAIN_W         = 24;
    localparam int Q30            = 30;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int TAB_N          = 1 << LOG_TABLE_BITS;
    localparam int MAG_W          = SAMPLE_BITS;
    localparam int POS_W          = $clog2(MAG_W);
    localparam int BIT_W          = $clog2(FRAC_BITS + 1);

    localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
    localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_KNEE      = 3'd1,
        REG_KNEE_COEF = 3'd2,
        REG_SLOPE     = 3'd3,
        REG_ATTACK    = 3'd4,
        REG_RELEASE   = 3'd5,
        REG_PRE_GAIN  = 3'd6,
        REG_POST_GAIN = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [23:0] threshold;
        logic        [22:0] knee_width;
        logic signed [23:0] knee_coef;
        logic        [16:0] slope;
        logic        [15:0] attack_coef;
        logic        [15:0] release_coef;
        logic signed [23:0] pre_gain;
        logic signed [23:0] post_gain;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_LOG,
        OP_PRE_ADD,
        OP_CURVE1,
        OP_KNEE_MUL,
        OP_CURVE2,
        OP_CURVE3,
        OP_SMOOTH1,
        OP_SMOOTH2,
        OP_EXP_INIT,
        OP_EXP_STEP,
        OP_EXP_FINAL
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BIT_W-1:0]  bit_idx;
    } t_cmd;

    typedef struct packed {
        logic exp_bit;
    } t_stat;

    function automatic logic [FRAC_BITS:0] log_tab(input int i);
        logic [63:0] y;
        logic [FRAC_BITS:0] acc;
        y = 64'(TAB_N + i) << (Q30 - LOG_TABLE_BITS);
        acc = '0;
        if (i >= TAB_N) begin
            acc = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end else begin
            for (int b = 1; b <= FRAC_BITS; b++) begin
                y = (y * y) >> Q30;
                if (y >= (64'd2 << Q30)) begin
                    acc[FRAC_BITS-b] = 1'b1;
                    y = y >> 1;
                end
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > v) b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [Q30+1:0] root_tab(input int idx);
        logic [63:0] r;
        r = 64'd2 << Q30;
        for (int b = 1; b <= FRAC_BITS; b++) begin
            if (b <= idx) r = isqrt64(r << Q30);
        end
        return r[Q30+1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/skc_if.sv */
// ----------------------------------------------------------------------------
// skc_if
// Valid/ready channel interfaces for frames, gains and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_frame_if;
    import skc_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface skc_gain_if;
    import skc_pkg::*;
    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] gain;
    modport source (output valid, gain, input ready);
    modport sink   (input valid, gain, output ready);
endinterface

interface skc_cfg_if;
    import skc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/skc_datapath.sv */
// ----------------------------------------------------------------------------
// skc_datapath
// Log conversion, knee curve, smoothing filter and serial exp2 unit.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_datapath
    import skc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    input  wire t_cfg                          i_cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] i_left,
    input  wire logic signed [SAMPLE_BITS-1:0] i_right,
    output t_stat                              o_stat,
    output logic [GAIN_W-1:0]                  o_gain
);

    localparam int TAB_W = FRAC_BITS + 1;

    typedef enum logic [1:0] {RG_BELOW, RG_KNEE, RG_ABOVE} t_region;

    logic [MAG_W-1:0]        r_mag;
    logic signed [LVL_W-1:0] r_lvl, r_x, r_y, r_g, r_s;
    logic signed [63:0]      r_prod;
    logic [33:0]             r_d2;
    t_region                 r_region;
    logic [FRAC_BITS-1:0]    r_f;
    logic [Q30+1:0]          r_acc;
    logic signed [LVL_W+1:0] r_n;
    logic [GAIN_W-1:0]       r_gain;

    function automatic logic signed [LVL_W-1:0] sat24(input logic signed [63:0] v);
        if (v > 64'(signed'(LVL_MAX))) return LVL_MAX;
        if (v < 64'(signed'(LVL_MIN))) return LVL_MIN;
        return v[LVL_W-1:0];
    endfunction

    // constant tables
    logic [TAB_W-1:0] w_log_lut [0:TAB_N];
    logic [Q30+1:0]   w_root_lut [0:FRAC_BITS];

    for (genvar k = 0; k <= TAB_N; k++) begin : g_log_lut
        assign w_log_lut[k] = log_tab(k);
    end

    for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_root_lut
        assign w_root_lut[k] = root_tab(k);
    end

    // log2 of the magnitude
    logic [POS_W-1:0]           w_p;
    logic [MAG_W-1:0]           w_frac;
    logic [LOG_TABLE_BITS-1:0]  w_idx;
    logic [LOG_TABLE_BITS:0]    w_lidx;
    logic [MAG_W-1:0]           w_r;
    logic [POS_W-1:0]           w_rem;
    logic [TAB_W-1:0]           w_t0, w_t1;
    logic [TAB_W+MAG_W-1:0]     w_interp;
    logic signed [LVL_W-1:0]    w_lvl;

    always_comb begin
        w_p = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (r_mag[k]) w_p = POS_W'(k);
        end
        w_frac = r_mag & ~(MAG_W'(1) << w_p);
        if (w_p >= POS_W'(LOG_TABLE_BITS)) begin
            w_rem = w_p - POS_W'(LOG_TABLE_BITS);
            w_idx = LOG_TABLE_BITS'(w_frac >> w_rem);
            w_r   = w_frac & ((MAG_W'(1) << w_rem) - MAG_W'(1));
        end else begin
            w_rem = '0;
            w_idx = LOG_TABLE_BITS'(w_frac << (POS_W'(LOG_TABLE_BITS) - w_p));
            w_r   = '0;
        end
        w_lidx = {1'b0, w_idx};
        w_t0 = w_log_lut[w_lidx];
        w_t1 = w_log_lut[w_lidx + (LOG_TABLE_BITS+1)'(1)];
        w_interp = ((TAB_W+MAG_W)'(w_t1 - w_t0) * (TAB_W+MAG_W)'(w_r)) >> w_rem;
        if (r_mag == '0) begin
            w_lvl = LVL_MIN;
        end else begin
            w_lvl = sat24((64'(signed'({1'b0, w_p})) - 64'(SAMPLE_BITS - 1))
                          * 64'(1 << FRAC_BITS)
                          + 64'(w_t0) + 64'(w_interp));
        end
    end

    // knee curve
    logic signed [LVL_W+1:0] w_xt, w_t, w_knee, w_d;
    logic signed [63:0]      w_d2;
    always_comb begin
        w_xt   = (LVL_W+2)'(r_x) - (LVL_W+2)'(i_cfg.threshold);
        w_t    = w_xt <<< 1;
        w_knee = (LVL_W+2)'(signed'({1'b0, i_cfg.knee_width}));
        w_d    = w_xt + (w_knee >>> 1);
        w_d2   = 64'((64'(w_d) * 64'(w_d)) >>> FRAC_BITS);
    end

    // smoothing
    logic signed [18:0] w_pole;
    logic signed [18:0] w_one_m;
    assign w_pole  = (r_g >= r_s) ? 19'(i_cfg.attack_coef) : 19'(i_cfg.release_coef);
    assign w_one_m = 19'(1 << FRAC_BITS) - w_pole;

    logic [2*(Q30+2)-1:0] w_mul;
    assign w_mul = (2*(Q30+2))'(r_acc) * (2*(Q30+2))'(w_root_lut[i_cmd.bit_idx]);

    logic signed [LVL_W+1:0] w_sh;
    logic [63:0]             w_ext;
    always_comb begin
        w_sh  = r_n + (LVL_W+2)'(FRAC_BITS - Q30);
        w_ext = '0;
        if (w_sh >= 0) begin
            if (w_sh > 24) w_ext = 64'(GAIN_W'('1));
            else w_ext = 64'(r_acc) << w_sh[4:0];
        end else if (-w_sh >= 63) begin
            w_ext = '0;
        end else begin
            w_ext = 64'(r_acc) >> (-w_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_mag <= MAG_W'((($signed({i_left[SAMPLE_BITS-1], i_left})
                        + $signed({i_right[SAMPLE_BITS-1], i_right})) < 0 ?
                        -($signed({i_left[SAMPLE_BITS-1], i_left})
                        + $signed({i_right[SAMPLE_BITS-1], i_right})) :
                        ($signed({i_left[SAMPLE_BITS-1], i_left})
                        + $signed({i_right[SAMPLE_BITS-1], i_right}))) >> 1);
                end
                OP_LOG: r_lvl <= w_lvl;
                OP_PRE_ADD: r_x <= sat24(64'(r_lvl) + 64'(i_cfg.pre_gain));
                OP_CURVE1: begin
                    r_d2 <= 34'(w_d2);
                    if (w_t < -w_knee) begin
                        r_region <= RG_BELOW;
                    end else if (w_t <= w_knee) begin
                        r_region <= RG_KNEE;
                    end else begin
                        r_region <= RG_ABOVE;
                        r_prod <= 64'(w_xt) * 64'(i_cfg.slope);
                    end
                end
                OP_KNEE_MUL: begin
                    if (r_region == RG_KNEE) begin
                        r_prod <= 64'(i_cfg.knee_coef) * 64'(signed'({1'b0, r_d2}));
                    end
                end
                OP_CURVE2: begin
                    unique case (r_region)
                        RG_BELOW: r_y <= r_x;
                        RG_KNEE:  r_y <= sat24(64'(r_x) + 64'(r_prod >>> FRAC_BITS));
                        default:  r_y <= sat24(64'(i_cfg.threshold)
                                               + 64'(r_prod >>> FRAC_BITS));
                    endcase
                end
                OP_CURVE3: r_g <= sat24(64'(r_lvl) - 64'(r_y));
                OP_SMOOTH1: r_prod <= 64'(w_pole) * 64'(r_s) + 64'(w_one_m) * 64'(r_g);
                OP_SMOOTH2: r_s <= sat24(64'(r_prod >>> FRAC_BITS));
                OP_EXP_INIT: begin
                    r_n   <= ((LVL_W+2)'(i_cfg.post_gain) - (LVL_W+2)'(r_s)) >>> FRAC_BITS;
                    r_f   <= FRAC_BITS'((LVL_W+2)'(i_cfg.post_gain) - (LVL_W+2)'(r_s));
                    r_acc <= (Q30+2)'(1) << Q30;
                end
                OP_EXP_STEP: r_acc <= (Q30+2)'(w_mul >> Q30);
                OP_EXP_FINAL: r_gain <= (w_ext > 64'(GAIN_W'('1))) ? '1 : GAIN_W'(w_ext);
                default: ;
            endcase
        end
    end

    assign o_stat.exp_bit = (i_cmd.bit_idx != '0) &&
                            r_f[FRAC_BITS - int'(i_cmd.bit_idx)];
    assign o_gain = r_gain;

endmodule

`default_nettype wire

/* rtl/skc_ctrl.sv */
// ----------------------------------------------------------------------------
// skc_ctrl
// Sequencer for one frame transaction and the output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_ctrl
    import skc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_EXP, S_FIN, S_OUT} t_state;

    t_state           r_state;
    t_op              r_op;
    logic [BIT_W-1:0] r_bit;
    logic             r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // root multiply only where the fraction bit is set
    assign o_cmd.op      = (r_state == S_IDLE && i_in_valid) ? OP_LOAD :
                           (r_op == OP_EXP_STEP && !i_stat.exp_bit) ? OP_IDLE : r_op;
    assign o_cmd.bit_idx = r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                        r_op    <= OP_LOG;
                    end
                end
                S_RUN: begin
                    unique case (r_op)
                        OP_LOG:      r_op <= OP_PRE_ADD;
                        OP_PRE_ADD:  r_op <= OP_CURVE1;
                        OP_CURVE1:   r_op <= OP_KNEE_MUL;
                        OP_KNEE_MUL: r_op <= OP_CURVE2;
                        OP_CURVE2:   r_op <= OP_CURVE3;
                        OP_CURVE3:   r_op <= OP_SMOOTH1;
                        OP_SMOOTH1:  r_op <= OP_SMOOTH2;
                        OP_SMOOTH2:  r_op <= OP_EXP_INIT;
                        default: begin
                            r_op    <= OP_EXP_STEP;
                            r_bit   <= BIT_W'(1);
                            r_state <= S_EXP;
                        end
                    endcase
                end
                S_EXP: begin
                    if (r_bit == BIT_W'(FRAC_BITS)) begin
                        r_op    <= OP_EXP_FINAL;
                        r_bit   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_bit <= r_bit + BIT_W'(1);
                    end
                end
                S_FIN: begin
                    r_op        <= OP_IDLE;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                default: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/soft_knee_compressor_gain.sv */
// ----------------------------------------------------------------------------
// soft_knee_compressor_gain
// Soft-knee feedforward compressor gain computer, one gain per stereo frame.
// ----------------------------------------------------------------------------
// One frame transaction yields one gain transaction. After the frame is taken,
// the steps are log conversion, knee curve, smoothing and exp2 setup, then
// the shared exp2 root multiplier at one fraction bit per cycle, then final
// scaling. A new frame is taken the cycle after the gain has been taken; a
// stalled output holds the input off. Register writes are taken at any time.
`default_nettype none

module soft_knee_compressor_gain
    import skc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    skc_frame_if.sink   frame,
    skc_gain_if.source  result,
    skc_cfg_if.sink     cfg
);

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{threshold: '0, knee_width: '0, knee_coef: '0, slope: 17'd65536,
                       attack_coef: '0, release_coef: '0, pre_gain: '0, post_gain: '0};
        end else if (cfg.valid) begin
            unique case (t_reg_idx'(cfg.index))
                REG_THRESHOLD: r_cfg.threshold    <= cfg.data;
                REG_KNEE:      r_cfg.knee_width   <= cfg.data[22:0];
                REG_KNEE_COEF: r_cfg.knee_coef    <= cfg.data;
                REG_SLOPE:     r_cfg.slope        <= cfg.data[16:0];
                REG_ATTACK:    r_cfg.attack_coef  <= cfg.data[15:0];
                REG_RELEASE:   r_cfg.release_coef <= cfg.data[15:0];
                REG_PRE_GAIN:  r_cfg.pre_gain     <= cfg.data;
                default:       r_cfg.post_gain    <= cfg.data;
            endcase
        end
    end

    skc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (frame.valid),
        .o_in_ready  (frame.ready),
        .o_out_valid (result.valid),
        .i_out_ready (result.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    skc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_cfg   (r_cfg),
        .i_left  (frame.left_sample),
        .i_right (frame.right_sample),
        .o_stat  (w_stat),
        .o_gain  (result.gain)
    );

endmodule

`default_nettype wire
